>>> rtl/ircfb_pkg.sv
// constants, types and helper functions of the ir climate frame builder
`default_nettype none

package ircfb_pkg;

	// command kinds
	localparam logic [1:0] KIND_CLIMATE = 2'd0;
	localparam logic [1:0] KIND_LIGHT   = 2'd1;
	localparam logic [1:0] KIND_DISPLAY = 2'd2;
	localparam logic [1:0] KIND_VOLTAGE = 2'd3;

	// operating modes
	localparam logic [1:0] MODE_OFF  = 2'd0;
	localparam logic [1:0] MODE_COOL = 2'd1;
	localparam logic [1:0] MODE_HEAT = 2'd2;
	localparam logic [1:0] MODE_FAN  = 2'd3;

	// configuration register indexes
	localparam logic CFG_USE_POWER_BIT = 1'b0;
	localparam logic CFG_PACKET_GAP_MS = 1'b1;

	localparam int CFG_DATA_W = 10;
	localparam int GAP_W      = 17;
	localparam int GAP_PROD_W = 20;

	// timing constants in microseconds
	localparam logic [GAP_W-1:0]      RAW_GAP_US      = 17'd25300;
	localparam logic [GAP_W-1:0]      MSG_SPACE_US    = 17'd20000;
	localparam logic [GAP_W-1:0]      DEF_PACKET_GAP  = 17'd40000;
	localparam logic [GAP_PROD_W-1:0] MAX_PACKET_GAP  = 20'd120000;
	localparam logic [GAP_PROD_W-1:0] ALT_DEFAULT_GAP = 20'd7000;
	localparam logic [GAP_PROD_W-1:0] MS_TO_US        = 20'd1000;

	// fixed packet bytes
	localparam logic [7:0] CSUM_SEED     = 8'h0A;
	localparam logic [7:0] MARKER_FIRST  = 8'h58;
	localparam logic [7:0] MARKER_SECOND = 8'h78;
	localparam logic [7:0] TAIL_FIRST_B5 = 8'h20;
	localparam logic [7:0] BOOST_BIT     = 8'h10;
	localparam logic [7:0] SWING_BIT     = 8'h80;
	localparam logic [7:0] POWER_FLAG    = 8'h08;
	localparam logic [7:0] ION_FLAG      = 8'h40;
	localparam logic [7:0] SLEEP_BIT     = 8'h80;
	localparam logic [7:0] ECO_TCODE     = 8'h08;
	localparam logic [3:0] ECO_TAIL_LO   = 4'h3;

	localparam logic [2:0] FAN_MAX   = 3'd5;
	localparam logic [1:0] FCODE_MAX = 2'd3;
	localparam logic [5:0] TEMP_MIN  = 6'd16;
	localparam logic [5:0] TEMP_MAX  = 6'd30;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] mode;
		logic [1:0] last_on_mode;
		logic [2:0] fan_speed;
		logic [5:0] target_temp;
		logic       eco_on;
		logic       boost_req;
		logic       sleep_req;
		logic       ion_on;
		logic       swing_req;
	} cmd_item_t;

	function automatic logic [7:0] bitrev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

	function automatic logic [31:0] pack4(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3);
		return {bitrev8(b0), bitrev8(b1), bitrev8(b2), bitrev8(b3)};
	endfunction

	// fixed words of the raw commands
	function automatic logic [31:0] raw_word(input logic [1:0] kind);
		logic [31:0] w;
		case (kind)
			KIND_LIGHT:   w = 32'h008844CC;
			KIND_DISPLAY: w = 32'h22AA66EE;
			KIND_VOLTAGE: w = 32'h55DD33BB;
			default:      w = 32'h0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ir_climate_frame_builder.sv
// top level of the ir climate frame builder: command register, word sequencer, output register
`default_nettype none

// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------------------
// in       | in_valid / in_ready   | kind, mode, last_on_mode, fan_speed, target_temp,
//          |                       | eco_on, boost_req, sleep_req, ion_on, swing_req
// out      | out_valid / out_ready | code_word, with_header, gap_after_us, last
// cfg      | cfg_we (no wait)      | cfg_index, cfg_data
//
// a climate item gives four words, one per cycle while out_ready does not stall, and
// holds the command register until its last word is loaded; a raw command gives one word
// the word for the current sequence index is built by short logic from the command
// register and loaded into the output register; the next item is taken in the cycle
// the last word of the current one is loaded
// arst_n clears the valid flags and the sequence index and loads the config registers
// with their reset values
// a stall on out_ready holds the output register and, behind it, the command register

module ir_climate_frame_builder (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [1:0]  mode,
	input  wire logic [1:0]  last_on_mode,
	input  wire logic [2:0]  fan_speed,
	input  wire logic [5:0]  target_temp,
	input  wire logic        eco_on,
	input  wire logic        boost_req,
	input  wire logic        sleep_req,
	input  wire logic        ion_on,
	input  wire logic        swing_req,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      code_word,
	output logic             with_header,
	output logic [16:0]      gap_after_us,
	output logic             last,

	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [ircfb_pkg::CFG_DATA_W-1:0] cfg_data
);

	// config registers; the packet gap is kept already converted to microseconds
	logic                              use_power_q;
	logic [ircfb_pkg::GAP_W-1:0]       pkt_gap_q;
	logic [ircfb_pkg::GAP_PROD_W-1:0]  gap_prod;
	logic [ircfb_pkg::GAP_W-1:0]       gap_new;

	// command register and word index
	ircfb_pkg::cmd_item_t cmd_s1;
	logic                 valid_s1;
	logic [1:0]           idx_q;

	// output register
	logic                              out_valid_q;
	logic [31:0]                       word_q;
	logic                              hdr_q;
	logic [ircfb_pkg::GAP_W-1:0]       gap_q;
	logic                              last_q;

	logic                 in_fire;
	logic                 load;
	logic                 is_raw;
	logic                 last_word;
	logic                 second;

	// field decode of the held command
	logic [1:0]  eff_mode;
	logic [2:0]  fan_eff;
	logic [1:0]  fcode;
	logic [5:0]  temp_cl;
	logic [7:0]  ctl;
	logic [7:0]  tcode;
	logic [7:0]  flags;
	logic [7:0]  marker;
	logic [7:0]  b5;
	logic [7:0]  b6;
	logic [3:0]  b7_lo;
	logic [3:0]  csum;
	logic [7:0]  b7;

	// next word
	logic [31:0]                 word_d;
	logic                        hdr_d;
	logic [ircfb_pkg::GAP_W-1:0] gap_d;

	// ms to us conversion of a packet gap write, with the default substitution
	always_comb begin
		gap_prod = ircfb_pkg::GAP_PROD_W'(cfg_data) * ircfb_pkg::MS_TO_US;
		if (gap_prod == ircfb_pkg::ALT_DEFAULT_GAP || gap_prod > ircfb_pkg::MAX_PACKET_GAP) begin
			gap_new = ircfb_pkg::DEF_PACKET_GAP;
		end else begin
			gap_new = gap_prod[ircfb_pkg::GAP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_power_q <= 1'b1;
			pkt_gap_q   <= ircfb_pkg::DEF_PACKET_GAP;
		end else if (cfg_we) begin
			case (cfg_index)
				ircfb_pkg::CFG_USE_POWER_BIT: use_power_q <= cfg_data[0];
				ircfb_pkg::CFG_PACKET_GAP_MS: pkt_gap_q   <= gap_new;
				default: ;
			endcase
		end
	end

	// handshake and sequencing
	assign is_raw    = (cmd_s1.kind != ircfb_pkg::KIND_CLIMATE);
	assign last_word = is_raw || (idx_q == 2'd3);
	assign load      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || (load && last_word);
	assign in_fire   = in_valid && in_ready;
	assign second    = idx_q[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= 2'd0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (load && last_word) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				idx_q <= last_word ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1 <= '{kind: kind, mode: mode, last_on_mode: last_on_mode,
				fan_speed: fan_speed, target_temp: target_temp, eco_on: eco_on,
				boost_req: boost_req, sleep_req: sleep_req, ion_on: ion_on,
				swing_req: swing_req};
		end
	end

	// packet bytes of the held command
	always_comb begin
		eff_mode = (cmd_s1.mode == ircfb_pkg::MODE_OFF) ? cmd_s1.last_on_mode : cmd_s1.mode;

		// turbo and out-of-range speeds both land on the top speed
		if (cmd_s1.boost_req || cmd_s1.fan_speed > ircfb_pkg::FAN_MAX) begin
			fan_eff = ircfb_pkg::FAN_MAX;
		end else begin
			fan_eff = cmd_s1.fan_speed;
		end
		fcode = (fan_eff > 3'(ircfb_pkg::FCODE_MAX)) ? ircfb_pkg::FCODE_MAX : fan_eff[1:0];

		// mode base: eco wins, off given as last mode counts as cool
		if (cmd_s1.eco_on) begin
			ctl = 8'h00;
		end else if (eff_mode == ircfb_pkg::MODE_HEAT) begin
			ctl = 8'h04;
		end else if (eff_mode == ircfb_pkg::MODE_FAN) begin
			ctl = 8'h03;
		end else begin
			ctl = 8'h01;
		end
		if (use_power_q && cmd_s1.mode != ircfb_pkg::MODE_OFF) begin
			ctl = ctl | ircfb_pkg::POWER_FLAG;
		end
		ctl = ctl | {2'b00, fcode, 4'h0};
		if (cmd_s1.ion_on) begin
			ctl = ctl | ircfb_pkg::ION_FLAG;
		end
		if (cmd_s1.sleep_req) begin
			ctl = ctl | ircfb_pkg::SLEEP_BIT;
		end

		if (cmd_s1.target_temp < ircfb_pkg::TEMP_MIN) begin
			temp_cl = ircfb_pkg::TEMP_MIN;
		end else if (cmd_s1.target_temp > ircfb_pkg::TEMP_MAX) begin
			temp_cl = ircfb_pkg::TEMP_MAX;
		end else begin
			temp_cl = cmd_s1.target_temp;
		end
		tcode = cmd_s1.eco_on ? ircfb_pkg::ECO_TCODE : {2'b00, temp_cl - ircfb_pkg::TEMP_MIN};

		flags = (cmd_s1.boost_req ? ircfb_pkg::BOOST_BIT : 8'h00)
			| (cmd_s1.swing_req ? ircfb_pkg::SWING_BIT : 8'h00);
		marker = second ? ircfb_pkg::MARKER_SECOND : ircfb_pkg::MARKER_FIRST;
		b5     = second ? 8'h00 : ircfb_pkg::TAIL_FIRST_B5;
		b6     = second ? {1'b0, fan_eff, 4'h0} : 8'h00;
		b7_lo  = (second && cmd_s1.eco_on) ? ircfb_pkg::ECO_TAIL_LO : 4'h0;

		// nibble checksum, only the low four bits survive
		csum = ircfb_pkg::CSUM_SEED[3:0] + ctl[3:0] + tcode[3:0] + flags[3:0] + marker[3:0]
			+ b5[7:4] + b6[7:4];
		b7 = {csum, b7_lo};

		if (is_raw) begin
			word_d = ircfb_pkg::raw_word(cmd_s1.kind);
			hdr_d  = 1'b1;
			gap_d  = ircfb_pkg::RAW_GAP_US;
		end else begin
			hdr_d = !idx_q[0];
			if (idx_q[0]) begin
				word_d = ircfb_pkg::pack4(8'h00, b5, b6, b7);
			end else begin
				word_d = ircfb_pkg::pack4(ctl, tcode, flags, marker);
			end
			case (idx_q)
				2'd1:    gap_d = pkt_gap_q;
				2'd3:    gap_d = ircfb_pkg::RAW_GAP_US;
				default: gap_d = ircfb_pkg::MSG_SPACE_US;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= word_d;
			hdr_q  <= hdr_d;
			gap_q  <= gap_d;
			last_q <= last_word;
		end
	end

	assign out_valid    = out_valid_q;
	assign code_word    = word_q;
	assign with_header  = hdr_q;
	assign gap_after_us = gap_q;
	assign last         = last_q;

endmodule

`default_nettype wire
